FILE: hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg - shared definitions for the differential drive odometry block
// Widths, reset values, register indexes, the CORDIC arctangent table and the
// result record handed from the CORDIC unit to the sequencer.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_PER_PULSE = 2'd1;

  // Register reset values.
  localparam logic [31:0] MPP_RESET = 32'd4294967;
  localparam logic [31:0] HPP_RESET = 32'd2278563;

  // Default number of CORDIC rotations.
  localparam int CORDIC_STEPS_DEF = 20;

  // CORDIC datapath width and the fixed gain correction (Q.30).
  localparam int CS_W = 33;
  localparam logic signed [CS_W-1:0] CORDIC_INV_GAIN = 33'sd652032874;

  // Pose width.
  localparam int POS_W = 48;

  // Result of one CORDIC run, with a one-cycle completion flag.
  typedef struct packed {
    logic                   done;
    logic signed [CS_W-1:0] cos_val;
    logic signed [CS_W-1:0] sin_val;
  } cordic_res_t;

  // Arctangent of 2^-i in binary angle units (2^32 is one full turn).
  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      5'd30: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic - iterative CORDIC for cosine and sine of a binary angle
// One rotation per cycle through a shared pair of barrel shifters and adders.
// Angles beyond a quarter turn are folded by half a turn and the result is
// negated at the end.
// ----------------------------------------------------------------------------
module ddo_cordic
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] angle,
  output cordic_res_t res
);

  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                   busy_r;
  logic                   done_r;
  logic                   flip_r;
  logic [STEP_W-1:0]      step_r;
  logic signed [CS_W-1:0] x_r;
  logic signed [CS_W-1:0] y_r;
  logic signed [CS_W-1:0] z_r;

  logic signed [31:0]     angle_s;
  logic                   fold;
  logic signed [CS_W-1:0] xs;
  logic signed [CS_W-1:0] ys;
  logic signed [CS_W-1:0] atan_v;
  logic signed [CS_W-1:0] x_nxt;
  logic signed [CS_W-1:0] y_nxt;
  logic signed [CS_W-1:0] z_nxt;

  // Fold the angle into the right half plane.
  assign angle_s = $signed(angle);
  assign fold    = (angle_s > 32'sd1073741824) || (angle_s < -32'sd1073741824);

  // One micro-rotation: shift, add or subtract by the sign of the residual angle.
  always_comb begin
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    atan_v = $signed({1'b0, atan_lookup(5'(step_r))});
    if (!z_r[CS_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_v;
    end
  end

  // Sequencer: load on start, then one rotation per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_INV_GAIN;
      y_r    <= '0;
      flip_r <= fold;
      if (fold) begin
        z_r <= CS_W'($signed(angle ^ 32'h8000_0000));
      end else begin
        z_r <= CS_W'(angle_s);
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Undo the fold on the way out.
  assign res.done    = done_r;
  assign res.cos_val = flip_r ? -x_r : x_r;
  assign res.sin_val = flip_r ? -y_r : y_r;

endmodule

FILE: hdl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry - dead-reckoning pose from wheel encoder counts
// Each request brings absolute left and right encoder counts. The block forms
// the count changes, the travel and heading step, rotates the travel through
// the mid-step heading and accumulates a saturating Q31.16 pose and a wrapping
// 32-bit binary-angle heading. One result request answers each input request.
// Requests are handled one at a time: the next request is taken only after
// the previous result has been pushed into the output register. The time per
// request is set by the iterative CORDIC, which does one rotation per cycle,
// and by the single shared 33x32 multiplier, which handles travel, heading
// step and the four partial products of the pose update in turn. A finished
// result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_wdata,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_left_count,
  input  logic signed [31:0]    in_right_count,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [31:0]    out_heading_angle
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MT   = 4'd1;
  localparam logic [3:0] S_MH   = 4'd2;
  localparam logic [3:0] S_HS   = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_PX0  = 4'd5;
  localparam logic [3:0] S_PX1  = 4'd6;
  localparam logic [3:0] S_PY0  = 4'd7;
  localparam logic [3:0] S_PY1  = 4'd8;
  localparam logic [3:0] S_PYE  = 4'd9;
  localparam logic [3:0] S_UPD  = 4'd10;
  localparam logic [3:0] S_PUSH = 4'd11;

  localparam logic [79:0] Q30_HALF = 80'd1 << 29;
  localparam logic signed [POS_W+3:0] POS_MAX_X = (52'sd1 <<< (POS_W - 1)) - 52'sd1;
  localparam logic signed [POS_W+3:0] POS_MIN_X = -(52'sd1 <<< (POS_W - 1));

  logic [3:0]              state_r;
  logic [31:0]             mpp_r;
  logic [31:0]             hpp_r;
  logic [31:0]             prev_left_r;
  logic [31:0]             prev_right_r;
  logic signed [POS_W-1:0] acc_x_r;
  logic signed [POS_W-1:0] acc_y_r;
  logic [31:0]             acc_heading_r;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_x_r;
  logic signed [POS_W-1:0] out_y_r;
  logic [31:0]             out_h_r;

  logic signed [33:0]      sum_r;
  logic signed [33:0]      diff_r;
  logic [64:0]             mult_r;
  logic [47:0]             tm_r;
  logic                    travel_neg_r;
  logic [31:0]             c_mag_r;
  logic                    c_neg_r;
  logic [31:0]             s_mag_r;
  logic                    s_neg_r;
  logic [79:0]             pacc_r;
  logic [49:0]             r_r;

  logic                    in_accept;
  logic                    out_free;
  logic [31:0]             dl_w;
  logic [31:0]             dr_w;
  logic [33:0]             sum_neg_v;
  logic [33:0]             diff_neg_v;
  logic [32:0]             sum_mag;
  logic [32:0]             diff_mag;
  logic [32:0]             mul_a;
  logic [31:0]             mul_b;
  logic [64:0]             p_round;
  logic [64:0]             p_plus1;
  logic [31:0]             dth;
  logic [31:0]             half;
  logic [79:0]             pacc_sum;
  logic                    cordic_start;
  logic [31:0]             mid_angle;
  logic [CS_W-1:0]         cos_neg_v;
  logic [CS_W-1:0]         sin_neg_v;
  cordic_res_t             cres;

  // No request is taken while reset is applied or an item is in progress.
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !rst_n || (state_r != S_IDLE);

  // Saturating pose update: acc minus the signed rotated step.
  function automatic logic signed [POS_W-1:0] pose_step(
    input logic signed [POS_W-1:0] acc,
    input logic [49:0]             mag,
    input logic                    neg
  );
    logic signed [POS_W+3:0] acc_x;
    logic signed [POS_W+3:0] mag_x;
    logic signed [POS_W+3:0] res;
    acc_x = (POS_W+4)'(acc);
    mag_x = $signed({2'b00, mag});
    res   = neg ? (acc_x + mag_x) : (acc_x - mag_x);
    if (res > POS_MAX_X) begin
      return POS_MAX_X[POS_W-1:0];
    end else if (res < POS_MIN_X) begin
      return POS_MIN_X[POS_W-1:0];
    end
    return res[POS_W-1:0];
  endfunction

  // Count changes, wrapped to 32 bits.
  assign dl_w = in_left_count - prev_left_r;
  assign dr_w = in_right_count - prev_right_r;

  // Magnitudes of the summed and differenced wheel steps.
  assign sum_neg_v  = -sum_r;
  assign diff_neg_v = -diff_r;
  assign sum_mag    = sum_r[33] ? sum_neg_v[32:0] : sum_r[32:0];
  assign diff_mag   = diff_r[33] ? diff_neg_v[32:0] : diff_r[32:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MT: begin
        mul_a = sum_mag;
        mul_b = mpp_r;
      end
      S_MH: begin
        mul_a = diff_mag;
        mul_b = hpp_r;
      end
      S_PX0: begin
        mul_a = {9'd0, tm_r[23:0]};
        mul_b = c_mag_r;
      end
      S_PX1: begin
        mul_a = {9'd0, tm_r[47:24]};
        mul_b = c_mag_r;
      end
      S_PY0: begin
        mul_a = {9'd0, tm_r[23:0]};
        mul_b = s_mag_r;
      end
      S_PY1: begin
        mul_a = {9'd0, tm_r[47:24]};
        mul_b = s_mag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Heading step and its floor half from the heading product.
  always_comb begin
    p_round = mult_r + 65'd65536;
    p_plus1 = mult_r + 65'd1;
    if (diff_r[33]) begin
      dth  = -mult_r[31:0];
      half = -p_plus1[32:1];
    end else begin
      dth  = mult_r[31:0];
      half = mult_r[32:1];
    end
  end

  assign mid_angle    = acc_heading_r + half;
  assign cordic_start = (state_r == S_HS);
  assign pacc_sum     = pacc_r + {mult_r[55:0], 24'd0};
  assign cos_neg_v    = -cres.cos_val;
  assign sin_neg_v    = -cres.sin_val;

  ddo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (mid_angle),
    .res   (cres)
  );

  // Shared multiplier with registered product.
  always_ff @(posedge clk) begin
    mult_r <= {32'd0, mul_a} * {33'd0, mul_b};
  end

  // Datapath scratch registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        sum_r  <= $signed({{2{dl_w[31]}}, dl_w}) + $signed({{2{dr_w[31]}}, dr_w});
        diff_r <= $signed({{2{dr_w[31]}}, dr_w}) - $signed({{2{dl_w[31]}}, dl_w});
      end
      S_MH: begin
        tm_r         <= p_round[64:17];
        travel_neg_r <= sum_r[33];
      end
      S_ROT: begin
        c_neg_r <= cres.cos_val[CS_W-1];
        s_neg_r <= cres.sin_val[CS_W-1];
        c_mag_r <= cres.cos_val[CS_W-1] ? cos_neg_v[31:0] : cres.cos_val[31:0];
        s_mag_r <= cres.sin_val[CS_W-1] ? sin_neg_v[31:0] : cres.sin_val[31:0];
      end
      S_PX1, S_PY1: begin
        pacc_r <= {15'd0, mult_r} + Q30_HALF;
      end
      S_PY0, S_PYE: begin
        r_r <= pacc_sum[79:30];
      end
      default: begin
      end
    endcase
  end

  // Sequencer, configuration, state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mpp_r         <= MPP_RESET;
      hpp_r         <= HPP_RESET;
      prev_left_r   <= '0;
      prev_right_r  <= '0;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      acc_heading_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Configuration writes; unknown indexes are ignored.
      if (cfg_we) begin
        if (cfg_index == REG_METERS_PER_PULSE) begin
          mpp_r <= cfg_wdata;
        end else if (cfg_index == REG_HEADING_PER_PULSE) begin
          hpp_r <= cfg_wdata;
        end
      end

      // The result slot fills on a push and holds until the result is taken.
      out_valid_r <= (state_r == S_PUSH && out_free) || (out_valid_r && out_stall);

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            prev_left_r  <= in_left_count;
            prev_right_r <= in_right_count;
            state_r      <= S_MT;
          end
        end
        S_MT:  state_r <= S_MH;
        S_MH:  state_r <= S_HS;
        S_HS: begin
          acc_heading_r <= acc_heading_r + dth;
          state_r       <= S_ROT;
        end
        S_ROT: begin
          if (cres.done) begin
            state_r <= S_PX0;
          end
        end
        S_PX0: state_r <= S_PX1;
        S_PX1: state_r <= S_PY0;
        S_PY0: state_r <= S_PY1;
        S_PY1: begin
          acc_x_r <= pose_step(acc_x_r, r_r, travel_neg_r ^ c_neg_r);
          state_r <= S_PYE;
        end
        S_PYE: state_r <= S_UPD;
        S_UPD: begin
          acc_y_r <= pose_step(acc_y_r, r_r, travel_neg_r ^ s_neg_r);
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result payload, loaded when the output slot frees up.
  always_ff @(posedge clk) begin
    if (state_r == S_PUSH && out_free) begin
      out_x_r <= acc_x_r;
      out_y_r <= acc_y_r;
      out_h_r <= acc_heading_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_heading_angle = $signed(out_h_r);

`ifndef SYNTHESIS
  // An accepted request starts the travel multiply next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_MT))
    else $error("accepted request did not start the sequencer");

  // The CORDIC only completes while the sequencer waits for it.
  a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cres.done |-> (state_r == S_ROT))
    else $error("CORDIC completed outside the rotation wait");

  // A result is pushed only from the push state.
  a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUSH))
    else $error("result appeared without a push");

  // A push with a free slot raises valid and returns to idle.
  a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("push did not deliver the result");
`endif

endmodule
